FILE: hdl/set_assoc_lru_cache_lookup_macros.svh
// Assertion macros shared by the cache lookup RTL.
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_MACROS_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define SLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the first condition holds, the second holds in the cycle after.
`define SLC_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SLC_ASSERT(lbl, prop, msg)
`define SLC_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/slc_pkg.sv
// Types and constants shared by the cache lookup modules.
`default_nettype none

package slc_pkg;

	localparam int unsigned TAG_W   = 64;
	localparam int unsigned ADDR_W  = 64;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned IDX_W   = 15;
	localparam int unsigned SIB_W   = 4;
	localparam int unsigned BOB_W   = 6;
	localparam int unsigned WIU_W   = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 6;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;

	localparam logic [2:0] OUT_MISS           = 3'd0;
	localparam logic [2:0] OUT_MISS_EVICT     = 3'd1;
	localparam logic [2:0] OUT_HIT            = 3'd2;
	localparam logic [2:0] OUT_MISS_HIT       = 3'd3;
	localparam logic [2:0] OUT_MISS_EVICT_HIT = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] address;
	} acc_req_t;

	typedef struct packed {
		logic [2:0]       outcome;
		logic [CNT_W-1:0] total_hits;
		logic [CNT_W-1:0] total_misses;
		logic [CNT_W-1:0] total_evictions;
	} acc_rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] reg_index;
		logic [CFG_DAT_W-1:0] wr_data;
	} cfg_wr_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOOKUP
	} slc_state_t;

	typedef struct packed {
		logic clear_wr;
		logic load;
		logic read;
		logic commit;
	} slc_cmd_t;

	typedef struct packed {
		logic clear_last;
	} slc_stat_t;

endpackage

`default_nettype wire

FILE: hdl/slc_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
`default_nettype none

interface slc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/slc_ctrl.sv
// Sequencer for the clearing pass and the per-item read, lookup and write-back.
`default_nettype none

module slc_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	input  slc_pkg::slc_stat_t stat,
	output slc_pkg::slc_cmd_t  cmd
);
	import slc_pkg::*;

	slc_state_t state_q;
	slc_state_t state_d;
	logic       out_valid_q;
	logic       commit_ok;

	assign commit_ok = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (commit_ok) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_READ: begin
				cmd.read = 1'b1;
			end
			ST_LOOKUP: begin
				cmd.commit = commit_ok;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/slc_dpath.sv
// Address split, set memory, way lookup with LRU update, and the running totals.
`default_nettype none

module slc_dpath #(
	parameter int unsigned NUM_SETS = 256,
	parameter int unsigned MAX_WAYS = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  slc_pkg::slc_cmd_t  cmd,
	output slc_pkg::slc_stat_t stat,
	input  slc_pkg::acc_req_t  req_data,
	input  wire                cfg_valid,
	input  slc_pkg::cfg_wr_t   cfg_data,
	output slc_pkg::acc_rsp_t  rsp_data
);
	import slc_pkg::*;

	localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned RANK_W = $clog2(MAX_WAYS + 1);
	localparam int unsigned RCP_SH = IDX_W + SET_W;
	localparam int unsigned RCP_W  = RCP_SH + 1;
	localparam int unsigned PROD_W = IDX_W + RCP_W;
	localparam int unsigned QN_W   = IDX_W + SET_W + 1;
	localparam longint unsigned RCP = ((64'd1 << RCP_SH) / NUM_SETS) + 1;
	localparam logic [RCP_W-1:0]  RCP_V     = RCP_W'(RCP);
	localparam logic [QN_W-1:0]   NSETS_V   = QN_W'(NUM_SETS);
	localparam logic [SET_W-1:0]  LAST_ROW  = SET_W'(NUM_SETS - 1);
	localparam logic [RANK_W-1:0] RANK_ONE  = RANK_W'(1);
	localparam logic [4:0]        MAX_WAYS5 = 5'(MAX_WAYS);

	typedef logic [MAX_WAYS-1:0]             way_vec_t;
	typedef logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_row_t;
	typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_row_t;

	function automatic way_vec_t first_one(input way_vec_t v);
		return v & (~v + MAX_WAYS'(1));
	endfunction

	// Configuration registers.
	logic [SIB_W-1:0] sib_q;
	logic [BOB_W-1:0] bob_q;
	logic [WIU_W-1:0] wiu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sib_q <= '0;
			bob_q <= '0;
			wiu_q <= WIU_W'(1);
		end else if (cfg_valid) begin
			case (cfg_data.reg_index)
				CFG_SET_INDEX_BITS:    sib_q <= cfg_data.wr_data[SIB_W-1:0];
				CFG_BLOCK_OFFSET_BITS: bob_q <= cfg_data.wr_data[BOB_W-1:0];
				CFG_WAYS_IN_USE:       wiu_q <= cfg_data.wr_data[WIU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Address split at the accepting edge; the set index is reduced modulo
	// the number of sets by a reciprocal multiply, finished in the read cycle.
	logic [ADDR_W-1:0] addr_sh;
	logic [IDX_W-1:0]  idx_mask;
	logic [IDX_W-1:0]  idx_c;
	logic [6:0]        tsum;
	logic [TAG_W-1:0]  tag_c;
	logic [PROD_W-1:0] prod_c;
	logic [IDX_W-1:0]  q_c;

	always_comb begin
		addr_sh  = req_data.address >> bob_q;
		idx_mask = IDX_W'((16'd1 << sib_q) - 16'd1);
		idx_c    = addr_sh[IDX_W-1:0] & idx_mask;
		tsum     = 7'(sib_q) + 7'(bob_q);
		tag_c    = tsum[6] ? '0 : (req_data.address >> tsum[5:0]);
		prod_c   = PROD_W'(idx_c) * PROD_W'(RCP_V);
		q_c      = IDX_W'(prod_c >> RCP_SH);
	end

	logic [1:0]       cmd_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] q_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_s1 <= req_data.cmd;
			tag_s1 <= tag_c;
			idx_s1 <= idx_c;
			q_s1   <= q_c;
		end
	end

	logic [QN_W-1:0]  qn;
	logic [SET_W-1:0] row_c;

	always_comb begin
		qn    = QN_W'(q_s1) * NSETS_V;
		row_c = SET_W'(QN_W'(idx_s1) - qn);
	end

	// Clearing pass over all rows after reset.
	logic [SET_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + SET_W'(1);
		end
	end

	assign stat.clear_last = (clr_q == LAST_ROW);

	// Set memory: one row per set, read and written whole.
	way_vec_t  mem_valid [NUM_SETS];
	tag_row_t  mem_tag   [NUM_SETS];
	rank_row_t mem_rank  [NUM_SETS];

	way_vec_t         rd_valid_s2;
	tag_row_t         rd_tag_s2;
	rank_row_t        rd_rank_s2;
	logic [SET_W-1:0] row_s2;

	way_vec_t  new_valid;
	tag_row_t  new_tag;
	rank_row_t new_rank;

	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			mem_valid[clr_q] <= '0;
			mem_rank[clr_q]  <= {MAX_WAYS{RANK_ONE}};
		end else if (cmd.commit) begin
			mem_valid[row_s2] <= new_valid;
			mem_tag[row_s2]   <= new_tag;
			mem_rank[row_s2]  <= new_rank;
		end
		if (cmd.read) begin
			rd_valid_s2 <= mem_valid[row_c];
			rd_tag_s2   <= mem_tag[row_c];
			rd_rank_s2  <= mem_rank[row_c];
			row_s2      <= row_c;
		end
	end

	// Way lookup and LRU update.
	logic [4:0]        wiu5;
	logic [4:0]        nways5;
	logic [RANK_W-1:0] nways;
	way_vec_t          in_use;
	way_vec_t          hit_vec;
	way_vec_t          inv_vec;
	way_vec_t          r1_vec;
	way_vec_t          vict_oh;
	logic              is_hit;
	logic              has_inv;
	logic [RANK_W-1:0] old_rank;

	always_comb begin
		wiu5 = 5'(wiu_q);
		if (wiu5 == 5'd0) begin
			nways5 = 5'd1;
		end else if (wiu5 > MAX_WAYS5) begin
			nways5 = MAX_WAYS5;
		end else begin
			nways5 = wiu5;
		end
		nways = RANK_W'(nways5);

		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w]  = (5'(w) < nways5);
			hit_vec[w] = in_use[w] && rd_valid_s2[w] && (rd_tag_s2[w] == tag_s1);
			inv_vec[w] = in_use[w] && !rd_valid_s2[w];
			r1_vec[w]  = in_use[w] && (rd_rank_s2[w] == RANK_ONE);
		end

		is_hit  = |hit_vec;
		has_inv = |inv_vec;
		if (is_hit) begin
			vict_oh = first_one(hit_vec);
		end else if (has_inv) begin
			vict_oh = first_one(inv_vec);
		end else if (|r1_vec) begin
			vict_oh = first_one(r1_vec);
		end else begin
			// A full set with no way of rank one loses way zero.
			vict_oh = MAX_WAYS'(1);
		end

		old_rank = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			old_rank = old_rank | (vict_oh[w] ? rd_rank_s2[w] : '0);
		end

		for (int w = 0; w < MAX_WAYS; w++) begin
			if (vict_oh[w]) begin
				new_rank[w] = nways;
				new_tag[w]  = tag_s1;
			end else begin
				new_tag[w] = rd_tag_s2[w];
				if (in_use[w] && (rd_rank_s2[w] > old_rank)) begin
					new_rank[w] = rd_rank_s2[w] - RANK_ONE;
				end else begin
					new_rank[w] = rd_rank_s2[w];
				end
			end
		end
		new_valid = rd_valid_s2 | vict_oh;
	end

	// Outcome and saturating totals.
	logic             modify;
	logic [1:0]       hit_inc;
	logic [2:0]       outcome;
	logic [CNT_W:0]   hit_sum;
	logic [CNT_W:0]   miss_sum;
	logic [CNT_W:0]   evict_sum;
	logic [CNT_W-1:0] hit_n;
	logic [CNT_W-1:0] miss_n;
	logic [CNT_W-1:0] evict_n;
	logic [CNT_W-1:0] hit_q;
	logic [CNT_W-1:0] miss_q;
	logic [CNT_W-1:0] evict_q;

	always_comb begin
		modify = (cmd_s1 == CMD_MODIFY);
		if (is_hit) begin
			hit_inc = modify ? 2'd2 : 2'd1;
			outcome = OUT_HIT;
		end else if (has_inv) begin
			hit_inc = modify ? 2'd1 : 2'd0;
			outcome = modify ? OUT_MISS_HIT : OUT_MISS;
		end else begin
			hit_inc = modify ? 2'd1 : 2'd0;
			outcome = modify ? OUT_MISS_EVICT_HIT : OUT_MISS_EVICT;
		end
		hit_sum   = {1'b0, hit_q} + (CNT_W + 1)'(hit_inc);
		miss_sum  = {1'b0, miss_q} + (CNT_W + 1)'(!is_hit);
		evict_sum = {1'b0, evict_q} + (CNT_W + 1)'(!is_hit && !has_inv);
		hit_n     = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
		miss_n    = miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
		evict_n   = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= '0;
			miss_q  <= '0;
			evict_q <= '0;
		end else if (cmd.commit) begin
			hit_q   <= hit_n;
			miss_q  <= miss_n;
			evict_q <= evict_n;
		end
	end

	acc_rsp_t rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.outcome         <= outcome;
			rsp_q.total_hits      <= hit_n;
			rsp_q.total_misses    <= miss_n;
			rsp_q.total_evictions <= evict_n;
		end
	end

	assign rsp_data = rsp_q;

endmodule

`default_nettype wire

FILE: hdl/set_assoc_lru_cache_lookup.sv
// Top level of the set-associative cache lookup with LRU replacement.
//
//  channel  role    payload                                          handshake
//  req      sink    cmd, address                                     valid/ready
//  rsp      source  outcome, total_hits, total_misses, total_evictions valid/ready
//  cfg      sink    reg_index, wr_data                               valid/ready
//
// An item passes through the accepting cycle, the set memory read, and the
// lookup cycle that writes the set back and loads the output register.
// After reset a clearing pass writes every set row with req.ready low.
// A result waiting on rsp holds the next item in its lookup cycle until taken.
// cfg.ready is always high; registers are to be written only between items, which the block does not enforce.
`default_nettype none
`include "set_assoc_lru_cache_lookup_macros.svh"

module set_assoc_lru_cache_lookup #(
	parameter int unsigned NUM_SETS = 256,
	parameter int unsigned MAX_WAYS = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	slc_stream_if.sink   req,
	slc_stream_if.source rsp,
	slc_stream_if.sink   cfg
);
	import slc_pkg::*;

	slc_cmd_t  ctl_cmd;
	slc_stat_t ctl_stat;

	assign cfg.ready = 1'b1;

	slc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (ctl_stat),
		.cmd       (ctl_cmd)
	);

	slc_dpath #(
		.NUM_SETS (NUM_SETS),
		.MAX_WAYS (MAX_WAYS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.stat      (ctl_stat),
		.req_data  (req.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.rsp_data  (rsp.data)
	);

	`SLC_ASSERT(a_one_cmd, $onehot0({ctl_cmd.clear_wr, ctl_cmd.load, ctl_cmd.read, ctl_cmd.commit}), "more than one datapath command")
	`SLC_ASSERT(a_no_accept_clear, !(ctl_cmd.clear_wr && req.ready), "input ready during clearing pass")
	`SLC_NEXT(a_load_read, ctl_cmd.load, ctl_cmd.read && !req.ready, "accepted item not followed by set read")
	`SLC_NEXT(a_commit_out, ctl_cmd.commit, rsp.valid, "committed item not presented on rsp")

endmodule

`default_nettype wire

FILE: test/set_assoc_lru_cache_lookup_test.sv
// Self-checking testbench for the set-associative LRU cache lookup block.
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_test;
	import slc_pkg::*;

	localparam int unsigned NUM_SETS = 256;
	localparam int unsigned MAX_WAYS = 8;
	localparam int unsigned LINES = NUM_SETS * MAX_WAYS;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SHOW_LIMIT = 10;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	slc_stream_if #(.T(acc_req_t)) req_ch ();
	slc_stream_if #(.T(acc_rsp_t)) rsp_ch ();
	slc_stream_if #(.T(cfg_wr_t)) cfg_ch ();

	set_assoc_lru_cache_lookup #(
		.NUM_SETS(NUM_SETS),
		.MAX_WAYS(MAX_WAYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Shadow copy of the cache lines, the totals and the registers.
	logic              way_valid [LINES];
	logic [TAG_W-1:0]  way_tag [LINES];
	logic [3:0]        way_rank [LINES];
	logic [CNT_W-1:0]  hit_count;
	logic [CNT_W-1:0]  miss_count;
	logic [CNT_W-1:0]  evict_count;
	logic [SIB_W-1:0]  cfg_set_bits;
	logic [BOB_W-1:0]  cfg_offset_bits;
	logic [WIU_W-1:0]  cfg_ways;

	acc_rsp_t    lookup_queue [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit          send_gaps_on = 1'b1;
	bit          recv_gaps_on = 1'b1;
	int          hold_left = 0;
	bit          took_rsp = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("set_assoc_lru_cache_lookup_test: FAIL");
			$finish;
		end
	end

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input int unsigned inc);
		logic [CNT_W:0] sum;
		sum = {1'b0, a} + (CNT_W + 1)'(inc);
		return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
	endfunction

	function automatic int unsigned eff_ways();
		if (cfg_ways == 0)
			return 1;
		if (cfg_ways > MAX_WAYS)
			return MAX_WAYS;
		return 32'(cfg_ways);
	endfunction

	// Make way w the most recently used; ranks above its old rank move down.
	function automatic void promote_way(input int unsigned base, input int unsigned w,
			input int unsigned nways);
		logic [3:0] old;
		old = way_rank[base + w];
		for (int unsigned i = 0; i < nways; i++)
			if (i != w && way_rank[base + i] > old)
				way_rank[base + i] = way_rank[base + i] - 4'd1;
		way_rank[base + w] = nways[3:0];
	endfunction

	function automatic acc_rsp_t lru_lookup(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
		acc_rsp_t res;
		int unsigned nways, ts, base, way;
		logic [63:0] idx;
		logic [TAG_W-1:0] tag;
		logic [2:0] outcome;
		bit modify, found;
		modify = (op == CMD_MODIFY);
		nways = eff_ways();
		ts = 32'(cfg_set_bits) + 32'(cfg_offset_bits);
		idx = (addr >> cfg_offset_bits) & ((64'd1 << cfg_set_bits) - 64'd1);
		tag = (ts >= 64) ? '0 : (addr >> ts);
		base = 32'((idx % NUM_SETS) * MAX_WAYS);
		way = nways;
		for (int unsigned i = 0; i < nways; i++)
			if (way == nways && way_valid[base + i] && way_tag[base + i] == tag)
				way = i;
		if (way < nways) begin
			promote_way(base, way, nways);
			hit_count = sat_add(hit_count, modify ? 2 : 1);
			outcome = OUT_HIT;
		end else begin
			miss_count = sat_add(miss_count, 1);
			for (int unsigned i = 0; i < nways; i++)
				if (way == nways && !way_valid[base + i])
					way = i;
			if (way < nways) begin
				outcome = modify ? OUT_MISS_HIT : OUT_MISS;
			end else begin
				// A full set left without a rank-1 way after a ways change loses way 0.
				evict_count = sat_add(evict_count, 1);
				way = 0;
				found = 1'b0;
				for (int unsigned i = 0; i < nways; i++)
					if (!found && way_rank[base + i] == 4'd1) begin
						way = i;
						found = 1'b1;
					end
				outcome = modify ? OUT_MISS_EVICT_HIT : OUT_MISS_EVICT;
			end
			way_valid[base + way] = 1'b1;
			way_tag[base + way] = tag;
			promote_way(base, way, nways);
			if (modify)
				hit_count = sat_add(hit_count, 1);
		end
		res.outcome = outcome;
		res.total_hits = hit_count;
		res.total_misses = miss_count;
		res.total_evictions = evict_count;
		return res;
	endfunction

	// Builds an address that lands on the given tag and set under the current setting.
	function automatic logic [ADDR_W-1:0] make_addr(input logic [63:0] tag,
			input logic [63:0] setv, input logic [63:0] off);
		int unsigned ts;
		logic [63:0] a;
		ts = 32'(cfg_set_bits) + 32'(cfg_offset_bits);
		a = (ts >= 64) ? 64'd0 : (tag << ts);
		a = a | ((setv & ((64'd1 << cfg_set_bits) - 64'd1)) << cfg_offset_bits);
		return a | (off & ((64'd1 << cfg_offset_bits) - 64'd1));
	endfunction

	// Result side: ready pacing at the falling edge, checks at the rising edge.
	initial begin : rsp_pacing
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (took_rsp) begin
				took_rsp = 1'b0;
				stall_left = recv_gaps_on ? $urandom_range(0, 6) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		acc_rsp_t want;
		acc_rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			took_rsp = 1'b1;
			got = rsp_ch.data;
			if (lookup_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= SHOW_LIMIT)
					$display("unexpected result: outcome %0d hits %0d misses %0d evictions %0d",
						got.outcome, got.total_hits, got.total_misses, got.total_evictions);
			end else begin
				want = lookup_queue.pop_front();
				if (got.outcome !== want.outcome || got.total_hits !== want.total_hits ||
						got.total_misses !== want.total_misses ||
						got.total_evictions !== want.total_evictions) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT) begin
						$display("mismatch at cycle %0d:", cycle_count);
						$display("  expected outcome %0d hits %0d misses %0d evictions %0d",
							want.outcome, want.total_hits, want.total_misses,
							want.total_evictions);
						$display("  actual   outcome %0d hits %0d misses %0d evictions %0d",
							got.outcome, got.total_hits, got.total_misses,
							got.total_evictions);
					end
				end
			end
		end
	end

	// Offers one access; valid stays high afterwards unless the next one waits.
	task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
		int gap;
		gap = send_gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= '{cmd: op, address: addr};
		do
			@(posedge clk);
		while (!req_ch.ready);
		lookup_queue.push_back(lru_lookup(op, addr));
		@(negedge clk);
	endtask

	// Stops offering, waits for every result, then lets the pipeline run dry.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (lookup_queue.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{reg_index: index, wr_data: value};
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (index)
			CFG_SET_INDEX_BITS:    cfg_set_bits = value[SIB_W-1:0];
			CFG_BLOCK_OFFSET_BITS: cfg_offset_bits = value[BOB_W-1:0];
			CFG_WAYS_IN_USE:       cfg_ways = value[WIU_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_cache_config(input logic [CFG_DAT_W-1:0] sets,
			input logic [CFG_DAT_W-1:0] offset, input logic [CFG_DAT_W-1:0] ways);
		cfg_write(CFG_SET_INDEX_BITS, sets);
		cfg_write(CFG_BLOCK_OFFSET_BITS, offset);
		cfg_write(CFG_WAYS_IN_USE, ways);
	endtask

	// Called only while nothing is offered; written at the rising edge so that the
	// result side reads it cleanly at the next falling edge.
	task automatic set_idling(input bit s_on, input bit r_on, input int hold);
		@(posedge clk);
		send_gaps_on = s_on;
		recv_gaps_on = r_on;
		hold_left = hold;
		@(negedge clk);
	endtask

	// Reset setting: one way and no index bits, so the whole address is the tag.
	task automatic test_single_way_extremes();
		send_access(CMD_LOAD, 64'd0);
		send_access(CMD_LOAD, 64'd0);
		send_access(CMD_STORE, '1);
		send_access(CMD_MODIFY, '1);
		send_access(CMD_MODIFY, 64'd0);
		send_access(CMD_UNUSED, 64'd0);
		send_access(CMD_STORE, 64'h5555_5555_5555_5555);
		send_access(CMD_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
	endtask

	task automatic test_replacement_corners();
		settle();
		write_cache_config(6'd2, 6'd4, 6'd4);
		send_access(CMD_MODIFY, make_addr(64'd1, 64'd1, '1));
		send_access(CMD_LOAD, make_addr(64'd2, 64'd1, 64'd0));
		send_access(CMD_STORE, make_addr(64'd3, 64'd1, 64'd5));
		send_access(CMD_LOAD, make_addr(64'd4, 64'd1, 64'd9));
		send_access(CMD_LOAD, make_addr(64'd1, 64'd1, 64'd0));
		send_access(CMD_STORE, make_addr(64'd2, 64'd1, 64'd3));
		send_access(CMD_LOAD, make_addr(64'd5, 64'd1, 64'd0));
		// Shrinking the set leaves the remaining ways without a rank-1 entry.
		settle();
		cfg_write(CFG_WAYS_IN_USE, 6'd2);
		send_access(CMD_MODIFY, make_addr(64'd6, 64'd1, 64'd0));
		settle();
		cfg_write(CFG_WAYS_IN_USE, 6'd0);
		send_access(CMD_LOAD, make_addr(64'd2, 64'd1, 64'd0));
		// Index plus offset covers the whole address, so every tag is zero.
		settle();
		write_cache_config(6'd15, 6'd63, 6'd15);
		send_access(CMD_LOAD, {$urandom, $urandom});
		send_access(CMD_MODIFY, {$urandom, $urandom});
		settle();
		cfg_write(CFG_UNUSED_INDEX, 6'h3F);
		send_access(CMD_STORE, {$urandom, $urandom});
		// Nine index bits: set 256 wraps onto set 0 with the same tag.
		settle();
		write_cache_config(6'd9, 6'd0, 6'd1);
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_LOAD, 64'h100);
	endtask

	// The result side holds off while accesses keep coming, so the input stalls.
	task automatic test_output_stall();
		settle();
		write_cache_config(6'd3, 6'd2, 6'd2);
		set_idling(1'b0, 1'b0, 120);
		for (int n = 0; n < 40; n++)
			send_access(2'($urandom_range(0, 3)), make_addr(64'($urandom_range(0, 3)),
				64'($urandom_range(0, 7)), {$urandom, $urandom}));
	endtask

	// Each phase picks a setting and mostly reuses a small pool of sets and tags.
	task automatic test_random_traffic();
		logic [63:0] tag_pool [12];
		logic [63:0] set_pool [4];
		logic [ADDR_W-1:0] addr;
		int unsigned n_sets, n_tags;
		for (int phase = 0; phase < 8; phase++) begin
			settle();
			case (phase)
				0: write_cache_config(6'd8, 6'd6, 6'd8);
				1: write_cache_config(6'd15, 6'd48, 6'd15);
				2: write_cache_config(6'd0, 6'd63, 6'd0);
				default: write_cache_config(6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			endcase
			set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, 0);
			n_sets = $urandom_range(1, 4);
			n_tags = eff_ways() + $urandom_range(0, 4);
			for (int k = 0; k < 4; k++) begin
				set_pool[k] = {$urandom, $urandom};
				if (k > 0 && cfg_set_bits > 8 && $urandom_range(0, 3) == 0)
					set_pool[k] = set_pool[0] ^ 64'h100;
			end
			for (int k = 0; k < 12; k++)
				tag_pool[k] = {$urandom, $urandom};
			for (int n = 0; n < 160; n++) begin
				if ($urandom_range(0, 6) == 0)
					addr = {$urandom, $urandom};
				else
					addr = make_addr(tag_pool[$urandom_range(0, n_tags - 1)],
						set_pool[$urandom_range(0, n_sets - 1)], {$urandom, $urandom});
				send_access(2'($urandom_range(0, 3)), addr);
			end
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		for (int i = 0; i < LINES; i++) begin
			way_valid[i] = 1'b0;
			way_tag[i] = '0;
			way_rank[i] = 4'd1;
		end
		hit_count = '0;
		miss_count = '0;
		evict_count = '0;
		cfg_set_bits = '0;
		cfg_offset_bits = '0;
		cfg_ways = 4'd1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_single_way_extremes();
		test_replacement_corners();
		test_output_stall();
		test_random_traffic();
		settle();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("set_assoc_lru_cache_lookup_test: PASS");
		else
			$display("set_assoc_lru_cache_lookup_test: FAIL");
		$finish;
	end

endmodule
